@@ hdl/two_level_page_table_mapper_assert.svh @@
// Assertion macros used by the checker of the page table mapper.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TLPTM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TLPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tlptm_pkg.sv @@
// ----------------------------------------------------------------------------
// tlptm_pkg
// Shared constants, codes and control structs of the page table mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package tlptm_pkg;

    localparam int unsigned NUM_FRAMES_DEF    = 16;
    localparam int unsigned ENTRIES_PER_TABLE = 1024;
    localparam int unsigned IDX_W             = 10;
    localparam int unsigned PAGE_SHIFT        = 12;
    localparam int unsigned PFN_W             = 20;
    localparam int unsigned WORD_W            = 32;

    // entry flag positions
    localparam int unsigned BIT_P  = 0;
    localparam int unsigned BIT_RW = 1;
    localparam int unsigned BIT_US = 2;

    // remainder unit: 9 bits hold any remainder below 256 shifted by one
    localparam int unsigned MOD_W     = 9;
    // base reduction: quotient by reciprocal multiply, then the remainder
    localparam int unsigned MOD_STEPS = 2;
    localparam int unsigned MOD_CNT_W = 1;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_NO_FRAME = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        RES_EMPTY    = 3'd0,
        RES_NO_TABLE = 3'd1,
        RES_NO_FRAME = 3'd2,
        RES_MAP      = 3'd3,
        RES_UNMAP    = 3'd4
    } t_res;

    typedef struct packed {
        logic capture;
        logic dir_rd;
        logic mod_start;
        logic mod_step;
        logic alloc;
        logic zero_wr;
        logic dir_wr;
        logic tbl_wr_map;
        logic tbl_rd;
        logic tbl_wr_unmap;
        logic clr_wr;
        logic init_alloc;
        logic set_res;
        t_res res;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_map;
        logic is_unmap;
        logic is_init;
        logic dir_present;
        logic alloc_empty;
        logic mod_last;
        logic sweep_last;
        logic clr_last;
        logic out_busy;
    } t_dp_sts;

    // Four steps of long division remainder, one nibble of dividend, MSB first.
    function automatic logic [MOD_W-1:0] mod_nibble(input logic [MOD_W-1:0] rem,
                                                    input logic [3:0]       nib,
                                                    input logic [MOD_W-1:0] div);
        logic [MOD_W-1:0] r;
        r = rem;
        for (int k = 3; k >= 0; k--) begin
            r = {r[MOD_W-2:0], nib[k]};
            if (r >= div) begin
                r = r - div;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tlptm_in_if.sv @@
// ----------------------------------------------------------------------------
// tlptm_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlptm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] virtual_addr;
    logic [3:0]  dir_frame;
    logic [19:0] phys_frame;
    logic        writable;

    modport source (output valid, cmd, virtual_addr, dir_frame, phys_frame, writable,
                    input ready);
    modport sink (input valid, cmd, virtual_addr, dir_frame, phys_frame, writable,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/tlptm_out_if.sv @@
// ----------------------------------------------------------------------------
// tlptm_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlptm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        tlb_flush;
    logic        table_allocated;
    logic [3:0]  table_frame;
    logic [31:0] entry_written;

    modport source (output valid, status, tlb_flush, table_allocated, table_frame,
                    entry_written, input ready);
    modport sink (input valid, status, tlb_flush, table_allocated, table_frame,
                  entry_written, output ready);
endinterface

`default_nettype wire

@@ hdl/tlptm_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlptm_ctrl
// Sequencer: walks one command through directory read, frame reduction,
// table allocation and entry writes, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tlptm_ctrl
    import tlptm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_DEC  = 11'b000_0000_0100,
        S_DCHK = 11'b000_0000_1000,
        S_MOD  = 11'b000_0001_0000,
        S_ZERO = 11'b000_0010_0000,
        S_DWR  = 11'b000_0100_0000,
        S_TWR  = 11'b000_1000_0000,
        S_TRD  = 11'b001_0000_0000,
        S_UWR  = 11'b010_0000_0000,
        S_RESP = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_ctl.res  = RES_EMPTY;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_ctl.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_map || i_sts.is_unmap) begin
                    o_ctl.dir_rd = 1'b1;
                    n_state      = S_DCHK;
                end else begin
                    o_ctl.init_alloc = i_sts.is_init;
                    o_ctl.set_res    = 1'b1;
                    o_ctl.res        = RES_EMPTY;
                    n_state          = S_RESP;
                end
            end
            S_DCHK: begin
                if (i_sts.dir_present) begin
                    o_ctl.mod_start = 1'b1;
                    n_state         = S_MOD;
                end else if (i_sts.is_unmap) begin
                    o_ctl.set_res = 1'b1;
                    o_ctl.res     = RES_NO_TABLE;
                    n_state       = S_RESP;
                end else if (i_sts.alloc_empty) begin
                    o_ctl.set_res = 1'b1;
                    o_ctl.res     = RES_NO_FRAME;
                    n_state       = S_RESP;
                end else begin
                    o_ctl.alloc = 1'b1;
                    n_state     = S_ZERO;
                end
            end
            S_MOD: begin
                o_ctl.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = i_sts.is_map ? S_TWR : S_TRD;
                end
            end
            S_ZERO: begin
                o_ctl.zero_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                o_ctl.dir_wr = 1'b1;
                n_state      = S_TWR;
            end
            S_TWR: begin
                o_ctl.tbl_wr_map = 1'b1;
                o_ctl.set_res    = 1'b1;
                o_ctl.res        = RES_MAP;
                n_state          = S_RESP;
            end
            S_TRD: begin
                o_ctl.tbl_rd = 1'b1;
                n_state      = S_UWR;
            end
            S_UWR: begin
                o_ctl.tbl_wr_unmap = 1'b1;
                o_ctl.set_res      = 1'b1;
                o_ctl.res          = RES_UNMAP;
                n_state            = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free or being drained
                if (!i_sts.out_busy) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/tlptm_dp.sv @@
// ----------------------------------------------------------------------------
// tlptm_dp
// Datapath: table store, allocator, frame remainder unit, command registers
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlptm_dp
    import tlptm_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_virtual_addr,
    input  logic [3:0]  i_dir_frame,
    input  logic [19:0] i_phys_frame,
    input  logic        i_writable,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  t_dp_cmd     i_ctl,
    output t_dp_sts     o_sts,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_tlb_flush,
    output logic        o_table_allocated,
    output logic [3:0]  o_table_frame,
    output logic [31:0] o_entry_written
);

    localparam int unsigned FW    = $clog2(NUM_FRAMES);
    localparam int unsigned DEPTH = NUM_FRAMES * ENTRIES_PER_TABLE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [MOD_W-1:0] NF_DIV = MOD_W'(NUM_FRAMES);
    localparam logic [FW:0]      NF_PTR = (FW + 1)'(NUM_FRAMES);

    // reciprocal of NUM_FRAMES, exact for every 20-bit base
    localparam int unsigned      RCP_W   = PFN_W + 1;
    localparam int unsigned      PROD_W  = PFN_W + RCP_W;
    localparam int unsigned      QN_W    = PFN_W + MOD_W;
    localparam int unsigned      RCP_SH  = PFN_W + FW;
    localparam longint unsigned  RCP_NUM = (64'd1 << RCP_SH) + NUM_FRAMES - 1;
    localparam logic [RCP_W-1:0] NF_RCP  = RCP_W'(RCP_NUM / NUM_FRAMES);

    // command registers
    logic [1:0]       r_cmd;
    logic [IDX_W-1:0] r_di;
    logic [IDX_W-1:0] r_ti;
    logic [PFN_W-1:0] r_pframe;
    logic             r_rw;
    logic [FW-1:0]    r_dframe;
    logic [FW-1:0]    r_tframe;
    logic             r_alloc;

    // remainder unit, sweeps, allocator
    logic [PFN_W-1:0]     w_base;
    logic [PROD_W-1:0]    w_prod;
    logic [PFN_W-1:0]     r_quot;
    logic [QN_W-1:0]      w_qn;
    logic [PFN_W-1:0]     w_rem;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic [IDX_W-1:0]     r_sweep;
    logic [AW-1:0]        r_clr_addr;
    logic [FW:0]          r_next_free;
    logic [3:0]           r_first_free;

    // table store
    logic [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic [WORD_W-1:0] r_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    logic [WORD_W-1:0] w_map_entry;
    logic [WORD_W-1:0] w_dir_entry;
    logic [WORD_W-1:0] w_unmap_entry;
    logic [7:0]        w_tframe8;

    // pending result and output register
    t_status           r_res_status;
    logic              r_res_flush;
    logic              r_res_alloc;
    logic [3:0]        r_res_frame;
    logic [WORD_W-1:0] r_res_entry;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_flush;
    logic              r_out_alloc;
    logic [3:0]        r_out_frame;
    logic [WORD_W-1:0] r_out_entry;

    assign w_base    = r_rdata[WORD_W-1:PAGE_SHIFT];
    assign w_prod    = PROD_W'(w_base) * PROD_W'(NF_RCP);
    assign w_qn      = QN_W'(r_quot) * QN_W'(NF_DIV);
    assign w_rem     = w_base - w_qn[PFN_W-1:0];
    assign w_tframe8 = 8'(r_tframe);

    always_comb begin
        w_map_entry                        = '0;
        w_map_entry[WORD_W-1:PAGE_SHIFT]   = r_pframe;
        w_map_entry[BIT_US]                = 1'b1;
        w_map_entry[BIT_RW]                = r_rw;
        w_map_entry[BIT_P]                 = 1'b1;

        // r_rdata still holds the directory entry; the frame clear wiped it
        // when the new table landed on the directory frame itself
        w_dir_entry = r_rdata;
        if (r_tframe == r_dframe) begin
            w_dir_entry[PAGE_SHIFT-1:0] = '0;
        end
        w_dir_entry[WORD_W-1:PAGE_SHIFT] = PFN_W'(r_tframe);
        w_dir_entry[BIT_RW]              = 1'b1;
        w_dir_entry[BIT_P]               = 1'b1;

        w_unmap_entry        = r_rdata;
        w_unmap_entry[BIT_P] = 1'b0;
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        unique if (i_ctl.clr_wr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
        end else if (i_ctl.zero_wr) begin
            w_we    = 1'b1;
            w_waddr = {r_tframe, r_sweep};
        end else if (i_ctl.dir_wr) begin
            w_we    = 1'b1;
            w_waddr = {r_dframe, r_di};
            w_wdata = w_dir_entry;
        end else if (i_ctl.tbl_wr_map) begin
            w_we    = 1'b1;
            w_waddr = {r_tframe, r_ti};
            w_wdata = w_map_entry;
        end else if (i_ctl.tbl_wr_unmap) begin
            w_we    = 1'b1;
            w_waddr = {r_tframe, r_ti};
            w_wdata = w_unmap_entry;
        end else begin
            w_we = 1'b0;
        end
    end

    assign w_re    = i_ctl.dir_rd | i_ctl.tbl_rd;
    assign w_raddr = i_ctl.tbl_rd ? {r_tframe, r_ti} : {r_dframe, r_di};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // command capture and per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd    <= i_cmd;
            r_di     <= i_virtual_addr[WORD_W-1 -: IDX_W];
            r_ti     <= i_virtual_addr[PAGE_SHIFT +: IDX_W];
            r_pframe <= i_phys_frame;
            r_rw     <= i_writable;
            r_dframe <= FW'(mod_nibble('0, i_dir_frame, NF_DIV));
            r_alloc  <= 1'b0;
        end
        if (i_ctl.alloc) begin
            r_tframe <= r_next_free[FW-1:0];
            r_alloc  <= 1'b1;
            r_sweep  <= '0;
        end
        if (i_ctl.zero_wr) begin
            r_sweep <= r_sweep + 1'b1;
        end
        if (i_ctl.mod_start) begin
            r_mod_cnt <= '0;
        end
        if (i_ctl.mod_step) begin
            // quotient first, then subtract it back out for the frame
            if (r_mod_cnt == '0) begin
                r_quot <= PFN_W'(w_prod >> RCP_SH);
            end else begin
                r_tframe <= FW'(w_rem);
            end
            r_mod_cnt <= r_mod_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr   <= '0;
            r_next_free  <= '0;
            r_first_free <= 4'd1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_first_free <= i_cfg_wdata;
            end
            if (i_ctl.init_alloc) begin
                r_next_free <= (MOD_W'(r_first_free) < NF_DIV) ?
                               (FW + 1)'(r_first_free) : NF_PTR;
            end else if (i_ctl.alloc) begin
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set_res) begin
            unique case (i_ctl.res)
                RES_NO_TABLE: begin
                    r_res_status <= ST_NO_TABLE;
                    r_res_flush  <= 1'b0;
                    r_res_alloc  <= 1'b0;
                    r_res_frame  <= '0;
                    r_res_entry  <= '0;
                end
                RES_NO_FRAME: begin
                    r_res_status <= ST_NO_FRAME;
                    r_res_flush  <= 1'b0;
                    r_res_alloc  <= 1'b0;
                    r_res_frame  <= '0;
                    r_res_entry  <= '0;
                end
                RES_MAP: begin
                    r_res_status <= ST_DONE;
                    r_res_flush  <= 1'b1;
                    r_res_alloc  <= r_alloc;
                    r_res_frame  <= w_tframe8[3:0];
                    r_res_entry  <= w_map_entry;
                end
                RES_UNMAP: begin
                    r_res_status <= ST_DONE;
                    r_res_flush  <= 1'b1;
                    r_res_alloc  <= 1'b0;
                    r_res_frame  <= w_tframe8[3:0];
                    r_res_entry  <= w_unmap_entry;
                end
                default: begin
                    r_res_status <= ST_DONE;
                    r_res_flush  <= 1'b0;
                    r_res_alloc  <= 1'b0;
                    r_res_frame  <= '0;
                    r_res_entry  <= '0;
                end
            endcase
        end
        if (i_ctl.load_out) begin
            r_out_status <= r_res_status;
            r_out_flush  <= r_res_flush;
            r_out_alloc  <= r_res_alloc;
            r_out_frame  <= r_res_frame;
            r_out_entry  <= r_res_entry;
        end
    end

    assign o_sts.is_map      = (r_cmd == CMD_MAP);
    assign o_sts.is_unmap    = (r_cmd == CMD_UNMAP);
    assign o_sts.is_init     = (r_cmd == CMD_INIT);
    assign o_sts.dir_present = r_rdata[BIT_P];
    assign o_sts.alloc_empty = (r_next_free >= NF_PTR);
    assign o_sts.mod_last    = (r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
    assign o_sts.sweep_last  = &r_sweep;
    assign o_sts.clr_last    = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.out_busy    = r_out_valid & ~i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_tlb_flush       = r_out_flush;
    assign o_table_allocated = r_out_alloc;
    assign o_table_frame     = r_out_frame;
    assign o_entry_written   = r_out_entry;

endmodule

`default_nettype wire

@@ hdl/two_level_page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// two_level_page_table_mapper
// Maps and unmaps pages in two-level page tables held in a local store.
// ----------------------------------------------------------------------------
// One command is worked at a time through a single table store that does one
// read and one write per cycle; the command channel takes the next command
// while the previous result still waits in the output register. A
// reciprocal-multiply remainder unit reduces the directory entry base to a
// store frame for a map into an existing table or an unmap of a present table;
// a map that allocates a table clears the new frame one word a cycle. After
// reset the whole store, NUM_FRAMES * 1024 words, is zeroed one word a cycle
// with the command channel held not ready; configuration writes are taken
// anytime.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_page_table_mapper
    import tlptm_pkg::*;
#(
    parameter int unsigned NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlptm_in_if.sink    i_in,
    tlptm_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);

    t_dp_cmd w_ctl;
    t_dp_sts w_sts;

    tlptm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    tlptm_dp #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (i_in.cmd),
        .i_virtual_addr    (i_in.virtual_addr),
        .i_dir_frame       (i_in.dir_frame),
        .i_phys_frame      (i_in.phys_frame),
        .i_writable        (i_in.writable),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_status          (o_out.status),
        .o_tlb_flush       (o_out.tlb_flush),
        .o_table_allocated (o_out.table_allocated),
        .o_table_frame     (o_out.table_frame),
        .o_entry_written   (o_out.entry_written)
    );

endmodule

`default_nettype wire

@@ hdl/tlptm_chk.sv @@
// ----------------------------------------------------------------------------
// tlptm_chk
// Port-level checks of the page table mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_level_page_table_mapper_assert.svh"

module tlptm_chk
    import tlptm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic        i_tlb_flush,
    input logic        i_table_allocated,
    input logic [3:0]  i_table_frame,
    input logic [31:0] i_entry_written
);

    // a failed command reports nothing else
    `TLPTM_ASSERT_NOW(a_err_empty, i_clk, i_rst_n, i_out_valid && (i_status != ST_DONE), !i_tlb_flush && !i_table_allocated && (i_table_frame == 4'd0) && (i_entry_written == 32'd0), "error result carries payload")

    // a new table always comes with a present user entry and a flush
    `TLPTM_ASSERT_NOW(a_alloc_entry, i_clk, i_rst_n, i_out_valid && i_table_allocated, i_tlb_flush && (i_status == ST_DONE) && i_entry_written[BIT_P] && i_entry_written[BIT_US], "allocating map result malformed")

    // one command in flight: no transfer right after a transfer
    `TLPTM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "command accepted while one is in flight")

    // a stalled result holds
    `TLPTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_entry_written) && $stable(i_table_frame), "stalled result changed")

endmodule

bind two_level_page_table_mapper tlptm_chk u_tlptm_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_status          (o_out.status),
    .i_tlb_flush       (o_out.tlb_flush),
    .i_table_allocated (o_out.table_allocated),
    .i_table_frame     (o_out.table_frame),
    .i_entry_written   (o_out.entry_written)
);

`default_nettype wire
